FILE: hw/rtl/sobel_pkg.sv
// Shared types and codes for the Sobel edge stream core.
package sobel_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 12;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam int unsigned MAX_WIDTH_DEFAULT = 2048;
    localparam int unsigned ROW_LIMIT         = 2048;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        run_last;
    } pix_out_t;

endpackage

FILE: hw/rtl/sobel_edge_stream_core.sv
// Streaming 3x3 Sobel edge detector over an RGB raster, with line memory and result queue.
//
// Pixels enter in raster order; the core tracks column and row itself against
// frame_width and frame_height. Border pixels come back unchanged with their
// coordinates; pixel (x,y) with x>=2 and y>=2 first releases interior pixel
// (x-1,y-1) as 255 minus the saturated Sobel magnitude on all three channels.
// A pixel that releases no interior result takes a request and then the
// line-memory read-modify-write. One that releases an interior result then
// goes through a squaring step and the eight steps of the bit-serial square
// root, and a further border step if it is also a border pixel. Results wait in
// a four-entry queue, so the core takes the next pixel while earlier results are
// still being drained. No clearing pass is needed after reset. Write frame size
// only while the core is idle.
module sobel_edge_stream_core #(
    parameter int unsigned MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  sobel_pkg::pix_in_t                pixel,
    output logic                              result_valid,
    input  logic                              result_stall,
    output sobel_pkg::pix_out_t               result
);
    import sobel_pkg::*;

    localparam int unsigned ADDR_W      = $clog2(MAX_WIDTH);
    localparam int unsigned EFF_W_LIMIT = (MAX_WIDTH < ROW_LIMIT) ? MAX_WIDTH : ROW_LIMIT;
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
    localparam logic [10:0] GRAY_RECIP  = 11'd683; // 683/2048 ~ 1/3, exact floor for sums <= 765

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_ROOT   = 5'b01000,
        ST_BORDER = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] frame_width_reg, frame_height_reg;
    logic [10:0] col_reg, row_reg;

    // effective frame size
    logic [11:0] eff_w, eff_h;
    always_comb
    begin
        eff_w = frame_width_reg;
        if (eff_w == 12'd0)
            eff_w = 12'd1;
        if (eff_w > 12'(EFF_W_LIMIT))
            eff_w = 12'(EFF_W_LIMIT);
        eff_h = frame_height_reg;
        if (eff_h == 12'd0)
            eff_h = 12'd1;
        if (eff_h > 12'(ROW_LIMIT))
            eff_h = 12'(ROW_LIMIT);
    end

    // queue
    pix_out_t             q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   q_head_reg, q_tail_reg;
    logic [Q_PTR_W:0]     q_count_reg;
    logic                 q_push, q_pop;
    pix_out_t             q_push_data;

    logic accept;
    assign cfg_ready   = 1'b1;
    assign pixel_stall = !((state_reg == ST_IDLE) && (q_count_reg <= (Q_PTR_W+1)'(Q_DEPTH - 2)));
    assign accept      = pixel_valid && !pixel_stall;

    // position of the incoming pixel
    logic [11:0] col_ext, row_adv, x_next_col, y_next_row;
    logic [10:0] cur_x, cur_y;
    logic        col_wrap;
    always_comb
    begin
        col_ext  = {1'b0, col_reg};
        col_wrap = (col_ext >= eff_w);
        row_adv  = col_wrap ? ({1'b0, row_reg} + 12'd1) : {1'b0, row_reg};
        cur_x    = col_wrap ? 11'd0 : col_reg;
        cur_y    = (row_adv >= eff_h) ? 11'd0 : row_adv[10:0];
        x_next_col = {1'b0, cur_x} + 12'd1;
        y_next_row = {1'b0, cur_y} + 12'd1;
    end

    logic [9:0]  rgb_sum;
    logic [19:0] gray_prod;
    assign rgb_sum   = 10'(pixel.red_in) + 10'(pixel.green_in) + 10'(pixel.blue_in);
    assign gray_prod = 20'(rgb_sum) * 20'(GRAY_RECIP);

    // item registers
    logic [10:0]       x_reg, y_reg;
    logic [7:0]        red_reg, green_reg, blue_reg, gray_reg;
    logic              border_reg, interior_reg;
    logic [ADDR_W-1:0] addr_reg;

    // line memory: upper row in [15:8], middle row in [7:0]
    logic [15:0] line_mem [MAX_WIDTH];
    logic [15:0] line_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            line_rd_reg <= line_mem[ADDR_W'(cur_x)];
        if (state_reg == ST_READ)
            line_mem[addr_reg] <= {line_rd_reg[7:0], gray_reg};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg        <= cur_x;
            y_reg        <= cur_y;
            addr_reg     <= ADDR_W'(cur_x);
            red_reg      <= pixel.red_in;
            green_reg    <= pixel.green_in;
            blue_reg     <= pixel.blue_in;
            gray_reg     <= gray_prod[18:11];
            interior_reg <= (cur_x >= 11'd2) && (cur_y >= 11'd2);
            border_reg   <= (cur_x == 11'd0) || (cur_y == 11'd0) ||
                            ({1'b0, cur_x} == eff_w - 12'd1) ||
                            ({1'b0, cur_y} == eff_h - 12'd1);
        end
    end

    // window: [0..2] column x-2 rows y-2..y, [3..5] column x-1
    logic [7:0] win_reg [6];
    logic [7:0] p_up, p_mid;
    assign p_up  = line_rd_reg[15:8];
    assign p_mid = line_rd_reg[7:0];

    logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0] gx_calc, gy_calc;
    always_comb
    begin
        gx_pos  = 10'(p_up) + 10'({p_mid, 1'b0}) + 10'(gray_reg);
        gx_neg  = 10'(win_reg[0]) + 10'({win_reg[1], 1'b0}) + 10'(win_reg[2]);
        gy_pos  = 10'(win_reg[2]) + 10'({win_reg[5], 1'b0}) + 10'(gray_reg);
        gy_neg  = 10'(win_reg[0]) + 10'({win_reg[3], 1'b0}) + 10'(p_up);
        gx_calc = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy_calc = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    logic signed [10:0] gx_reg, gy_reg;
    logic signed [21:0] gx_sq, gy_sq;
    logic [21:0]        sq_reg;
    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    // bit-serial root, one result bit a cycle
    logic [7:0]  root_reg, root_trial, root_upd;
    logic [2:0]  step_reg;
    logic [15:0] trial_sq;
    logic        sat;
    always_comb
    begin
        root_trial = root_reg | (8'd1 << step_reg);
        trial_sq   = 16'(root_trial) * 16'(root_trial);
        root_upd   = (trial_sq <= sq_reg[15:0]) ? root_trial : root_reg;
        sat        = |sq_reg[21:16];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            gx_reg <= gx_calc;
            gy_reg <= gy_calc;
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_reg   <= 22'(gx_sq) + 22'(gy_sq);
            root_reg <= 8'd0;
            step_reg <= 3'd7;
        end
        if (state_reg == ST_ROOT)
        begin
            root_reg <= root_upd;
            step_reg <= step_reg - 3'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            col_reg          <= 11'd0;
            row_reg          <= 11'd0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (x_next_col >= eff_w)
                begin
                    col_reg <= 11'd0;
                    row_reg <= (y_next_row >= eff_h) ? 11'd0 : y_next_row[10:0];
                end
                else
                begin
                    col_reg <= x_next_col[10:0];
                    row_reg <= cur_y;
                end
            end
            if (state_reg == ST_READ)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= p_up;
                win_reg[4] <= p_mid;
                win_reg[5] <= gray_reg;
            end
        end
    end

    pix_out_t border_res, interior_res;
    logic [7:0] mag_inv;
    always_comb
    begin
        mag_inv = sat ? 8'd0 : ~root_upd;
        border_res.pos_x     = x_reg;
        border_res.pos_y     = y_reg;
        border_res.red_out   = red_reg;
        border_res.green_out = green_reg;
        border_res.blue_out  = blue_reg;
        border_res.run_last  = 1'b1;
        interior_res.pos_x     = x_reg - 11'd1;
        interior_res.pos_y     = y_reg - 11'd1;
        interior_res.red_out   = mag_inv;
        interior_res.green_out = mag_inv;
        interior_res.blue_out  = mag_inv;
        interior_res.run_last  = !border_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        q_push      = 1'b0;
        q_push_data = border_res;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (interior_reg)
                    state_next = ST_SQUARE;
                else
                begin
                    q_push     = border_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SQUARE:
                state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (step_reg == 3'd0)
                begin
                    q_push      = 1'b1;
                    q_push_data = interior_res;
                    state_next  = border_reg ? ST_BORDER : ST_IDLE;
                end
            end
            ST_BORDER:
            begin
                q_push     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result queue
    assign result_valid = (q_count_reg != '0);
    assign result       = q_mem[q_head_reg];
    assign q_pop        = result_valid && !result_stall;

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_tail_reg] <= q_push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (q_push)
                q_tail_reg <= q_tail_reg + Q_PTR_W'(1);
            if (q_pop)
                q_head_reg <= q_head_reg + Q_PTR_W'(1);
            if (q_push && !q_pop)
                q_count_reg <= q_count_reg + (Q_PTR_W+1)'(1);
            else if (q_pop && !q_push)
                q_count_reg <= q_count_reg - (Q_PTR_W+1)'(1);
        end
    end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the streaming Sobel edge core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sobel_pkg::*;

    localparam int unsigned LINE_MAX   = MAX_WIDTH_DEFAULT;
    localparam int unsigned SETTLE_CYC = 20;
    localparam int unsigned HOLD_CYC   = 300;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned RUN_PIX    = 300;
    localparam int unsigned RAND_PIX   = 1300;

    // Models the core: tracks position, gray lines and window, queues the
    // results each accepted pixel should release.
    class edge_scoreboard;
        bit [11:0] width_reg;
        bit [11:0] height_reg;
        bit [11:0] col_at;
        bit [11:0] row_at;
        bit [7:0]  upper_gray[LINE_MAX];
        bit [7:0]  middle_gray[LINE_MAX];
        bit [7:0]  win[6];
        pix_out_t  due_pixels[$];
        int        errors;
        int        pixels_seen;
        int        results_checked;

        function new();
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            col_at     = '0;
            row_at     = '0;
            foreach (win[i]) win[i] = '0;
            foreach (upper_gray[i]) upper_gray[i] = '0;
            foreach (middle_gray[i]) middle_gray[i] = '0;
            errors          = 0;
            pixels_seen     = 0;
            results_checked = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_FRAME_WIDTH)
                width_reg = data;
            else if (index == CFG_FRAME_HEIGHT)
                height_reg = data;
        endfunction

        function int waiting();
            return due_pixels.size();
        endfunction

        // floor(sqrt(v)), clamped to 255
        function int unsigned root_clamped(int unsigned v);
            int unsigned r;
            int unsigned t;
            r = 0;
            if (v >= 65536)
                return 255;
            for (int unsigned b = 128; b != 0; b = b >> 1)
            begin
                t = r | b;
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function void note_pixel(pix_in_t p);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            int unsigned mag;
            int          gx;
            int          gy;
            int          sum;
            int          n;
            bit [7:0]    lum;
            bit [7:0]    up_x;
            bit [7:0]    mid_x;
            bit [7:0]    level;
            pix_out_t    outs[2];

            w = (width_reg == 0) ? 1 : width_reg;
            if (w > LINE_MAX)
                w = LINE_MAX;
            h = (height_reg == 0) ? 1 : height_reg;
            if (h > ROW_LIMIT)
                h = ROW_LIMIT;
            sum = p.red_in + p.green_in + p.blue_in;
            lum = 8'(sum / 3);
            n = 0;
            pixels_seen++;

            // counters left past the frame edge by a size change wrap here
            if (col_at >= w)
            begin
                col_at = '0;
                row_at = row_at + 1'b1;
            end
            if (row_at >= h)
                row_at = '0;
            x = col_at;
            y = row_at;
            up_x  = upper_gray[x];
            mid_x = middle_gray[x];

            if (x >= 2 && y >= 2)
            begin
                gx = (int'(up_x) + 2 * int'(mid_x) + int'(lum))
                   - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
                gy = (int'(win[2]) + 2 * int'(win[5]) + int'(lum))
                   - (int'(win[0]) + 2 * int'(win[3]) + int'(up_x));
                mag   = root_clamped(gx * gx + gy * gy);
                level = 8'(255 - mag);
                outs[n].pos_x     = 11'(x - 1);
                outs[n].pos_y     = 11'(y - 1);
                outs[n].red_out   = level;
                outs[n].green_out = level;
                outs[n].blue_out  = level;
                outs[n].run_last  = 1'b0;
                n++;
            end
            if (x == 0 || y == 0 || x == w - 1 || y == h - 1)
            begin
                outs[n].pos_x     = 11'(x);
                outs[n].pos_y     = 11'(y);
                outs[n].red_out   = p.red_in;
                outs[n].green_out = p.green_in;
                outs[n].blue_out  = p.blue_in;
                outs[n].run_last  = 1'b0;
                n++;
            end
            if (n > 0)
                outs[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++)
                due_pixels.push_back(outs[i]);

            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up_x;
            win[4] = mid_x;
            win[5] = lum;
            upper_gray[x]  = mid_x;
            middle_gray[x] = lum;

            col_at = 12'(x + 1);
            if (col_at >= w)
            begin
                col_at = '0;
                row_at = 12'(y + 1);
                if (row_at >= h)
                    row_at = '0;
            end
        endfunction

        function void check_result(pix_out_t got);
            pix_out_t want;
            results_checked++;
            if (due_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: x=%0d y=%0d rgb=%0d/%0d/%0d",
                         $time, got.pos_x, got.pos_y, got.red_out, got.green_out,
                         got.blue_out);
                return;
            end
            want = due_pixels.pop_front();
            if (got.pos_x !== want.pos_x)
            begin
                errors++;
                $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
            end
            if (got.pos_y !== want.pos_y)
            begin
                errors++;
                $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
            end
            if (got.red_out !== want.red_out)
            begin
                errors++;
                $display("%0t: red_out at (%0d,%0d) expected %0d actual %0d", $time,
                         want.pos_x, want.pos_y, want.red_out, got.red_out);
            end
            if (got.green_out !== want.green_out)
            begin
                errors++;
                $display("%0t: green_out at (%0d,%0d) expected %0d actual %0d", $time,
                         want.pos_x, want.pos_y, want.green_out, got.green_out);
            end
            if (got.blue_out !== want.blue_out)
            begin
                errors++;
                $display("%0t: blue_out at (%0d,%0d) expected %0d actual %0d", $time,
                         want.pos_x, want.pos_y, want.blue_out, got.blue_out);
            end
            if (got.run_last !== want.run_last)
            begin
                errors++;
                $display("%0t: run_last at (%0d,%0d) expected %0d actual %0d", $time,
                         want.pos_x, want.pos_y, want.run_last, got.run_last);
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   pixel_valid  = 1'b0;
    logic                   pixel_stall;
    pix_in_t                pixel        = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    pix_out_t               result;

    edge_scoreboard sb;
    int unsigned    cycle_count = 0;
    bit             no_idle     = 1'b0;
    bit             hold_req    = 1'b0;
    bit             hold_done   = 1'b0;
    int unsigned    hold_left   = 0;
    int             frames_sent = 0;
    int             rand_pixels = 0;
    int             paint_base;
    int             paint_sx;
    int             paint_sy;

    sobel_edge_stream_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // result side: random stalls, plus one long hold-off to back the core up
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYC;
            result_stall <= 1'b1;
        end
        else if (no_idle)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 34);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(index, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(pix_in_t p);
        while (!no_idle && $urandom_range(99) < 34)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (pixel_stall);
        sb.note_pixel(p);
    endtask

    // let every queued result out, then give a pixel with no result time to finish
    task automatic settle();
        pixel_valid <= 1'b0;
        while (sb.waiting() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        settle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    function automatic pix_in_t test_card(int x, int y);
        pix_in_t p;
        if (x == 3 && y == 0)
            p = '{red_in: 8'hFF, green_in: 8'h00, blue_in: 8'h80};
        else if (x == 0 && y == 3)
            p = '{red_in: 8'h01, green_in: 8'hFE, blue_in: 8'h7F};
        else if (x == 1 && y == 2)
            p = '{red_in: 8'h55, green_in: 8'hAA, blue_in: 8'h33};
        else if (x >= 2)
            p = '{red_in: 8'hFF, green_in: 8'hFF, blue_in: 8'hFF};
        else
            p = '0;
        return p;
    endfunction

    function automatic pix_in_t paint(int style, int x, int y);
        pix_in_t  p;
        bit [7:0] v;
        case (style)
            0: p = pix_in_t'(24'($urandom));
            1:
            begin
                v = $urandom_range(1) ? 8'hFF : 8'h00;
                p = '{red_in: v, green_in: v, blue_in: v};
            end
            default:
            begin
                // ramps give mid-range gradients; wrap-round adds the odd sharp step
                v = 8'(paint_base + x * paint_sx + y * paint_sy);
                p = '{red_in: v + 8'($urandom_range(3)), green_in: v,
                      blue_in: v - 8'($urandom_range(3))};
            end
        endcase
        return p;
    endfunction

    task automatic send_frame(int w, int h, int style);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_pixel(paint(style, x, y));
        frames_sent++;
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_CAP)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int fw;
        int fh;
        int style;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small test card: flat areas, hard edges, mixed channels, 0/1/2 results
        write_reg(CFG_FRAME_WIDTH, 12'd4);
        write_reg(CFG_FRAME_HEIGHT, 12'd4);
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 4; x++)
                send_pixel(test_card(x, y));
        frames_sent++;

        // shrink the frame part-way through a row: column then row wrap
        set_frame(12'd6, 12'd5);
        repeat (3) send_pixel(paint(0, 0, 0));
        settle();
        write_reg(CFG_FRAME_WIDTH, 12'd2);
        repeat (2) send_pixel(paint(0, 0, 0));
        settle();
        write_reg(CFG_FRAME_HEIGHT, 12'd0);
        repeat (2) send_pixel(paint(0, 0, 0));
        settle();
        write_reg(CFG_FRAME_WIDTH, 12'd0);
        repeat (2) send_pixel(paint(1, 0, 0));

        // long stretch of one row against an oversized width, back to back on both sides
        set_frame(12'd4095, 12'd1);
        no_idle = 1'b1;
        repeat (RUN_PIX) send_pixel(paint(0, 0, 0));
        no_idle = 1'b0;

        // one column against an oversized height; the result side holds off meanwhile
        set_frame(12'd0, 12'd4095);
        hold_req <= 1'b1;
        repeat (RUN_PIX) send_pixel(paint(0, 0, 0));

        while (rand_pixels < RAND_PIX)
        begin
            // keep the size sometimes, so frames run back to back
            if (rand_pixels == 0 || $urandom_range(1))
            begin
                fw = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                fh = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
                set_frame(CFG_DATA_W'(fw), CFG_DATA_W'(fh));
            end
            style      = $urandom_range(2);
            paint_base = $urandom_range(255);
            paint_sx   = $urandom_range(40);
            paint_sy   = $urandom_range(40);
            send_frame((fw == 0) ? 1 : fw, (fh == 0) ? 1 : fh, style);
            rand_pixels += ((fw == 0) ? 1 : fw) * ((fh == 0) ? 1 : fh);
        end

        settle();
        $display("%0d pixels in %0d frames (%0d random), %0d results checked, %0d cycles",
                 sb.pixels_seen, frames_sent, rand_pixels, sb.results_checked, cycle_count);
        $display("frames 1x1 to 40x24, oversized size registers, mid-frame resize, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sobel_pkg.sv
hw/rtl/sobel_edge_stream_core.sv
sim/testbench.sv
